// ----- hdl/alfg_pkg.sv -----
// shared constants and register codes for the linear fade gain block
package alfg_pkg;

    // sample path width, fixed by the stream format
    localparam int SAMPLE_W     = 32;
    // default width of positions and position registers
    localparam int POS_BITS_DEF = 32;

    // configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_END    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_START = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH   = 2'd3;

    // sample format codes
    localparam int FMT_W = 2;
    localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;

    localparam logic [FMT_W-1:0]    FMT_RESET    = FMT_S16;
    localparam logic [CFG_W-1:0]    FADE_IN_RST  = 32'h0000_0000;
    localparam logic [CFG_W-1:0]    FADE_OUT_RST = 32'hFFFF_FFFF;
    localparam logic [CFG_W-1:0]    TOTAL_RST    = 32'hFFFF_FFFF;

    // silence level of unsigned 8-bit samples
    localparam logic signed [SAMPLE_W-1:0] SILENCE_U8 = 32'sd128;

    // one quotient bit per divider stage
    localparam int DIV_STAGES = SAMPLE_W;
    // abs, partial products, product sum, divider, sign fix
    localparam int SCALE_LAT  = DIV_STAGES + 4;
    // decode, select, two scale units, output register
    localparam int LATENCY    = 2 * SCALE_LAT + 3;

endpackage

// ----- hdl/audio_linear_fade_gain.sv -----
// top level: linear fade-in and fade-out gain on a pcm sample stream
//
//  channel   direction  transfer when               payload
//  -------   ---------  --------------------------  ------------------------------
//  sample    in         start && !busy at clk edge  i_sample_in, i_position
//  result    out        o_valid, one cycle, no hold  o_sample_out
//  config    in         i_cfg_we at clk edge         i_cfg_idx, i_cfg_data
//
//  one sample may enter every cycle while busy is low; results leave in transfer
//  order after the decode and select stages, two scale units with 32-stage quotient
//  pipelines (one quotient bit per stage) and the output register
//  synchronous active-low reset clears all valid bits and sets the config registers
//  to their reset values; busy is high while reset is held and in the cycle after it
//  the receiver cannot stall, so the pipeline advances every cycle
module audio_linear_fade_gain
    import alfg_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // sample transfer
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic [31:0]                i_position,
    // result strobe
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    // register writes
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    localparam int PW    = POSITION_BITS;
    localparam int TAG_W = 2 * PW + 1;

    // config registers
    logic [FMT_W-1:0] r_fmt;
    logic [CFG_W-1:0] r_fin;
    logic [CFG_W-1:0] r_fos;
    logic [CFG_W-1:0] r_tot;

    logic r_live;

    // positions masked to the configured width
    logic [PW-1:0] pos_m;
    logic [PW-1:0] fin_m;
    logic [PW-1:0] fos_m;
    logic [PW-1:0] tot_m;

    logic                       accept;
    logic signed [SAMPLE_W-1:0] n_a_d;

    // decode and compare stage
    logic                       r_a_vld;
    logic signed [SAMPLE_W-1:0] r_a_d;
    logic [PW-1:0]              r_a_pos;
    logic                       r_a_fin;
    logic                       r_a_fout;
    logic                       r_a_u8;

    // ratio select stage
    logic                       r_b_vld;
    logic signed [SAMPLE_W-1:0] r_b_d;
    logic [PW-1:0]              r_b_num1;
    logic [PW-1:0]              r_b_den1;
    logic [PW-1:0]              r_b_num2;
    logic [PW-1:0]              r_b_den2;
    logic                       r_b_u8;

    // scale unit links
    logic                       s1_vld;
    logic signed [SAMPLE_W-1:0] s1_q;
    logic [TAG_W-1:0]           s1_tag;
    logic                       s2_vld;
    logic signed [SAMPLE_W-1:0] s2_q;
    logic                       s2_u8;

    // output register
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out;

    // 8-bit samples get their silence level back
    function automatic logic signed [SAMPLE_W-1:0] add_silence(
        input logic signed [SAMPLE_W-1:0] q,
        input logic                       u8
    );
        add_silence = u8 ? q + SILENCE_U8 : q;
    endfunction

    assign accept = start && !busy;
    assign busy   = !r_live;

    assign pos_m = PW'(i_position);
    assign fin_m = PW'(r_fin);
    assign fos_m = PW'(r_fos);
    assign tot_m = PW'(r_tot);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= FMT_RESET;
            r_fin  <= FADE_IN_RST;
            r_fos  <= FADE_OUT_RST;
            r_tot  <= TOTAL_RST;
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SAMPLE_FORMAT:  r_fmt <= i_cfg_data[FMT_W-1:0];
                    REG_FADE_IN_END:    r_fin <= i_cfg_data;
                    REG_FADE_OUT_START: r_fos <= i_cfg_data;
                    REG_TOTAL_LENGTH:   r_tot <= i_cfg_data;
                    default:            r_fmt <= r_fmt;
                endcase
            end
        end
    end

    // sample relative to the silence level; unused format code acts as 32-bit
    always_comb begin
        unique case (r_fmt)
            FMT_U8:  n_a_d = $signed({24'd0, i_sample_in[7:0]}) - SILENCE_U8;
            FMT_S16: n_a_d = {{(SAMPLE_W-16){i_sample_in[15]}}, i_sample_in[15:0]};
            default: n_a_d = i_sample_in;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_a_vld   <= accept;
            r_b_vld   <= r_a_vld;
            r_out_vld <= s2_vld;
        end

        // past the stream end neither fade applies
        r_a_d    <= n_a_d;
        r_a_pos  <= pos_m;
        r_a_fin  <= (pos_m < tot_m) && (pos_m < fin_m);
        r_a_fout <= (pos_m < tot_m) && (pos_m >= fos_m);
        r_a_u8   <= (r_fmt == FMT_U8);

        // an inactive fade scales by one over one
        r_b_d    <= r_a_d;
        r_b_num1 <= r_a_fin  ? r_a_pos         : PW'(1);
        r_b_den1 <= r_a_fin  ? fin_m           : PW'(1);
        r_b_num2 <= r_a_fout ? tot_m - r_a_pos : PW'(1);
        r_b_den2 <= r_a_fout ? tot_m - fos_m   : PW'(1);
        r_b_u8   <= r_a_u8;

        r_out <= add_silence(s2_q, s2_u8);
    end

    // fade-in first
    alfg_scale #(
        .PW    (PW),
        .TAG_W (TAG_W)
    ) u_fade_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_b_vld),
        .i_d     (r_b_d),
        .i_num   (r_b_num1),
        .i_den   (r_b_den1),
        .i_tag   ({r_b_num2, r_b_den2, r_b_u8}),
        .o_vld   (s1_vld),
        .o_q     (s1_q),
        .o_tag   (s1_tag)
    );

    // then fade-out on the already scaled distance from silence
    alfg_scale #(
        .PW    (PW),
        .TAG_W (1)
    ) u_fade_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s1_vld),
        .i_d     (s1_q),
        .i_num   (s1_tag[TAG_W-1:PW+1]),
        .i_den   (s1_tag[PW:1]),
        .i_tag   (s1_tag[0]),
        .o_vld   (s2_vld),
        .o_q     (s2_q),
        .o_tag   (s2_u8)
    );

    assign o_valid      = r_out_vld;
    assign o_sample_out = r_out;

endmodule

// ----- hdl/alfg_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module alfg_div
    import alfg_pkg::*;
#(
    parameter int PW    = POS_BITS_DEF,
    parameter int TAG_W = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  logic [SAMPLE_W+PW-1:0] i_dividend,
    input  logic [PW-1:0]          i_den,
    input  logic [TAG_W-1:0]       i_tag,
    output logic                   o_vld,
    output logic [SAMPLE_W-1:0]    o_quo,
    output logic [TAG_W-1:0]       o_tag
);

    localparam int QW = DIV_STAGES;

    logic              r_vld [QW];
    logic [PW-1:0]     r_rem [QW];
    logic [QW-1:0]     r_low [QW];
    logic [PW-1:0]     r_den [QW];
    logic [TAG_W-1:0]  r_tag [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic             vld_in;
        logic [PW-1:0]    rem_in;
        logic [QW-1:0]    low_in;
        logic [PW-1:0]    den_in;
        logic [TAG_W-1:0] tag_in;
        logic [PW:0]      trial;
        logic [PW:0]      diff;
        logic             take;

        if (k == 0) begin : g_first
            // quotient fits QW bits, so the top part is already below the divisor
            assign vld_in = i_vld;
            assign rem_in = i_dividend[QW+PW-1:QW];
            assign low_in = i_dividend[QW-1:0];
            assign den_in = i_den;
            assign tag_in = i_tag;
        end else begin : g_next
            assign vld_in = r_vld[k-1];
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign den_in = r_den[k-1];
            assign tag_in = r_tag[k-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
            r_rem[k] <= take ? diff[PW-1:0] : trial[PW-1:0];
            // dividend bits shift out at the top, quotient bits shift in below
            r_low[k] <= {low_in[QW-2:0], take};
            r_den[k] <= den_in;
            r_tag[k] <= tag_in;
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_quo = r_low[QW-1];
    assign o_tag = r_tag[QW-1];

endmodule

// ----- hdl/alfg_scale.sv -----
// signed scale by num/den with truncation toward zero, fully pipelined
module alfg_scale
    import alfg_pkg::*;
#(
    parameter int PW    = POS_BITS_DEF,
    parameter int TAG_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic signed [SAMPLE_W-1:0] i_d,
    input  logic [PW-1:0]              i_num,
    input  logic [PW-1:0]              i_den,
    input  logic [TAG_W-1:0]           i_tag,
    output logic                       o_vld,
    output logic signed [SAMPLE_W-1:0] o_q,
    output logic [TAG_W-1:0]           o_tag
);

    localparam int LO_W   = (PW + 1) / 2;
    localparam int HI_W   = PW - LO_W;
    localparam int PROD_W = SAMPLE_W + PW;

    // magnitude stage
    logic                r1_vld;
    logic [SAMPLE_W-1:0] r1_mag;
    logic                r1_neg;
    logic [PW-1:0]       r1_num;
    logic [PW-1:0]       r1_den;
    logic [TAG_W-1:0]    r1_tag;

    // partial product stage
    logic                     r2_vld;
    logic [SAMPLE_W+LO_W-1:0] r2_pp_lo;
    logic [SAMPLE_W+HI_W-1:0] r2_pp_hi;
    logic                     r2_neg;
    logic [PW-1:0]            r2_den;
    logic [TAG_W-1:0]         r2_tag;

    // product stage
    logic              r3_vld;
    logic [PROD_W-1:0] r3_prod;
    logic              r3_neg;
    logic [PW-1:0]     r3_den;
    logic [TAG_W-1:0]  r3_tag;

    // sign fix stage
    logic                       r4_vld;
    logic signed [SAMPLE_W-1:0] r4_q;
    logic [TAG_W-1:0]           r4_tag;

    logic                div_vld;
    logic [SAMPLE_W-1:0] div_quo;
    logic [TAG_W:0]      div_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= div_vld;
        end

        r1_mag <= i_d[SAMPLE_W-1] ? SAMPLE_W'(-i_d) : SAMPLE_W'(i_d);
        r1_neg <= i_d[SAMPLE_W-1];
        r1_num <= i_num;
        r1_den <= i_den;
        r1_tag <= i_tag;

        r2_pp_lo <= (SAMPLE_W+LO_W)'(r1_mag) * (SAMPLE_W+LO_W)'(r1_num[LO_W-1:0]);
        r2_pp_hi <= (SAMPLE_W+HI_W)'(r1_mag) * (SAMPLE_W+HI_W)'(r1_num[PW-1:LO_W]);
        r2_neg   <= r1_neg;
        r2_den   <= r1_den;
        r2_tag   <= r1_tag;

        r3_prod <= PROD_W'(r2_pp_lo) + (PROD_W'(r2_pp_hi) << LO_W);
        r3_neg  <= r2_neg;
        r3_den  <= r2_den;
        r3_tag  <= r2_tag;

        r4_q   <= div_tag[TAG_W] ? -$signed(div_quo) : $signed(div_quo);
        r4_tag <= div_tag[TAG_W-1:0];
    end

    alfg_div #(
        .PW    (PW),
        .TAG_W (TAG_W + 1)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r3_vld),
        .i_dividend (r3_prod),
        .i_den      (r3_den),
        .i_tag      ({r3_neg, r3_tag}),
        .o_vld      (div_vld),
        .o_quo      (div_quo),
        .o_tag      (div_tag)
    );

    assign o_vld = r4_vld;
    assign o_q   = r4_q;
    assign o_tag = r4_tag;

endmodule

// ----- hdl/alfg_chk.sv -----
// port-level timing checks for the fade gain block, bound to the top level
module alfg_chk
    import alfg_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    // every transfer is followed by its result strobe
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("transfer without result after pipeline latency");

    // no result without a transfer at the matching edge
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without matching transfer");

    // reset flushes the pipeline: no result in the cycle after reset
    a_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // sample port is closed just after reset
    a_busy_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

endmodule

bind audio_linear_fade_gain alfg_chk u_alfg_chk (.*);
